/* rtl/core/tcpoae_pkg.sv */
// ----------------------------------------------------------------------------
// TCP option address extractor package
// Shared types and constants for the options walker and its result buffer.
// ----------------------------------------------------------------------------
package tcpoae_pkg;

   // Option kinds with a fixed meaning.
   localparam logic [7:0] KIND_EOL = 8'd0;
   localparam logic [7:0] KIND_NOP = 8'd1;

   // Smallest legal option length, and the smallest one that carries an address.
   localparam logic [7:0] MIN_OPT_LEN  = 8'd2;
   localparam logic [7:0] ADDR_MIN_LEN = 8'd8;

   // Offsets inside the address option where the port and the address end.
   localparam logic [5:0] PORT_LAST_OFS = 6'd3;
   localparam logic [5:0] ADDR_LAST_OFS = 6'd7;

   // A TCP header without options is five 32-bit words long.
   localparam logic [3:0] BASE_HDR_WORDS = 4'd5;
   localparam logic [5:0] BASE_HDR_BYTES = 6'd20;
   localparam logic [5:0] MAX_AREA_BYTES = 6'd40;

   // Configuration register indexes and reset values.
   localparam logic CSR_ADDR_KIND = 1'b0;
   localparam logic CSR_ADDR_LEN  = 1'b1;
   localparam logic [7:0] ADDR_KIND_RESET = 8'd254;
   localparam logic [5:0] ADDR_LEN_RESET  = 6'd8;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_KIND,
      PH_LEN,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      OUT_FOUND     = 3'd0,
      OUT_EOL       = 3'd1,
      OUT_SILLY     = 3'd2,
      OUT_PARTIAL   = 3'd3,
      OUT_EXHAUSTED = 3'd4
   } outcome_type;

   typedef struct packed {
      logic        address_found;
      outcome_type outcome;
      logic [15:0] client_port;
      logic [31:0] client_ip;
   } rsp_word_type;

endpackage

/* rtl/core/tcpoae_walker.sv */
// ----------------------------------------------------------------------------
// TCP option walker
// Steps through the options area one byte per accepted word and decides
// the outcome of each header.
// ----------------------------------------------------------------------------
module tcpoae_walker import tcpoae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   option_byte,
   input  logic         first_byte,
   input  logic [3:0]   data_offset,
   input  logic [7:0]   cfg_kind,
   input  logic [5:0]   cfg_len,
   output logic         res_valid,
   output rsp_word_type res_word
);

   phase_type   phase_ff, phase_in;
   logic [5:0]  left_ff, left_in;
   logic [5:0]  size_ff, size_in;
   logic [5:0]  offset_ff, offset_in;
   logic        match_ff, match_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] ip_ff, ip_in;

   logic        short_hdr;
   logic [5:0]  start_left;
   phase_type   eff_phase;
   logic [5:0]  eff_left;
   logic [5:0]  left_dec;
   logic [5:0]  off_inc;
   logic        too_long;
   logic        body_done;
   logic        emit;
   outcome_type code;

   assign short_hdr  = first_byte && (data_offset <= BASE_HDR_WORDS);
   assign start_left = short_hdr ? 6'd0 : ({2'b00, data_offset} << 2) - BASE_HDR_BYTES;
   assign eff_phase  = first_byte ? PH_KIND : phase_ff;
   assign eff_left   = first_byte ? start_left : left_ff;
   assign left_dec   = eff_left - 6'd1;
   assign off_inc    = offset_ff + 6'd1;
   // The length byte itself is still counted in bytes_left.
   assign too_long   = {1'b0, option_byte} > ({3'b000, eff_left} + 9'd1);
   assign body_done  = ({1'b0, off_inc} + 7'd1) >= {1'b0, size_ff};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (short_hdr) begin
            phase_in = PH_IDLE;
         end else begin
            unique case (eff_phase)
               PH_KIND: begin
                  priority if (option_byte == KIND_EOL) begin
                     phase_in = PH_IDLE;
                  end else if (option_byte == KIND_NOP) begin
                     phase_in = (left_dec == 6'd0) ? PH_IDLE : PH_KIND;
                  end else if (eff_left <= 6'd1) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  priority if (option_byte < MIN_OPT_LEN || too_long) begin
                     phase_in = PH_IDLE;
                  end else if (option_byte == MIN_OPT_LEN) begin
                     phase_in = (left_dec == 6'd0) ? PH_IDLE : PH_KIND;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  priority if (match_ff) begin
                     phase_in = (off_inc == ADDR_LAST_OFS) ? PH_IDLE : PH_BODY;
                  end else if (body_done) begin
                     phase_in = (left_dec == 6'd0) ? PH_IDLE : PH_KIND;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Counters, capture and result decision.
   always_comb begin
      left_in   = left_ff;
      size_in   = size_ff;
      offset_in = offset_ff;
      match_in  = match_ff;
      port_in   = port_ff;
      ip_in     = ip_ff;
      emit      = 1'b0;
      code      = OUT_FOUND;
      if (accept) begin
         if (first_byte) begin
            match_in  = 1'b0;
            size_in   = 6'd0;
            offset_in = 6'd0;
            left_in   = start_left;
         end
         if (short_hdr) begin
            emit = 1'b1;
            code = OUT_EXHAUSTED;
         end else begin
            unique case (eff_phase)
               PH_KIND: begin
                  priority if (option_byte == KIND_EOL) begin
                     emit = 1'b1;
                     code = OUT_EOL;
                  end else if (option_byte == KIND_NOP) begin
                     left_in = left_dec;
                     if (left_dec == 6'd0) begin
                        emit = 1'b1;
                        code = OUT_EXHAUSTED;
                     end
                  end else if (eff_left <= 6'd1) begin
                     emit = 1'b1;
                     code = OUT_PARTIAL;
                  end else begin
                     match_in  = (option_byte == cfg_kind);
                     left_in   = left_dec;
                     offset_in = 6'd0;
                  end
               end
               PH_LEN: begin
                  priority if (option_byte < MIN_OPT_LEN) begin
                     emit = 1'b1;
                     code = OUT_SILLY;
                  end else if (too_long) begin
                     emit = 1'b1;
                     code = OUT_PARTIAL;
                  end else begin
                     // The length fits the area, which is at most 40 bytes here.
                     size_in   = option_byte[5:0];
                     match_in  = match_ff && (option_byte == {2'b00, cfg_len})
                                 && (option_byte >= ADDR_MIN_LEN);
                     offset_in = 6'd1;
                     left_in   = left_dec;
                     port_in   = 16'd0;
                     ip_in     = 32'd0;
                     if (option_byte == MIN_OPT_LEN && left_dec == 6'd0) begin
                        emit = 1'b1;
                        code = OUT_EXHAUSTED;
                     end
                  end
               end
               PH_BODY: begin
                  offset_in = off_inc;
                  left_in   = left_dec;
                  if (match_ff) begin
                     if (off_inc <= PORT_LAST_OFS) begin
                        port_in = {port_ff[7:0], option_byte};
                     end else begin
                        ip_in = {ip_ff[23:0], option_byte};
                     end
                     if (off_inc == ADDR_LAST_OFS) begin
                        emit = 1'b1;
                        code = OUT_FOUND;
                     end
                  end else if (body_done && left_dec == 6'd0) begin
                     emit = 1'b1;
                     code = OUT_EXHAUSTED;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign res_valid              = emit;
   assign res_word.address_found = (code == OUT_FOUND);
   assign res_word.outcome       = code;
   assign res_word.client_port   = (code == OUT_FOUND) ? port_in : 16'd0;
   assign res_word.client_ip     = (code == OUT_FOUND) ? ip_in : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         left_ff   <= 6'd0;
         size_ff   <= 6'd0;
         offset_ff <= 6'd0;
         match_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         size_ff   <= size_in;
         offset_ff <= offset_in;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
      ip_ff   <= ip_in;
   end

   // The area never holds more than forty bytes.
   assert property (@(posedge clock) disable iff (reset) left_ff <= MAX_AREA_BYTES)
      else $error("bytes_left beyond the largest options area");

   // Any walk that is still in progress, inside an option or between options, has bytes left to read.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN || phase_ff == PH_BODY || phase_ff == PH_KIND) |-> left_ff != 6'd0)
      else $error("walk in progress with an empty area");

   // A matching option finishes at the last address byte.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY && match_ff) |-> offset_ff < ADDR_LAST_OFS)
      else $error("matching option ran past its address bytes");

   // An option body is only entered for options longer than two bytes.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> size_ff > MIN_OPT_LEN[5:0])
      else $error("option body with a length of two or less");

endmodule

/* rtl/core/tcpoae_rsp_buf.sv */
// ----------------------------------------------------------------------------
// TCP option result buffer
// Output register with one skid entry between the walker and the result port.
// ----------------------------------------------------------------------------
module tcpoae_rsp_buf import tcpoae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         full,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         rsp_stall
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = push;
            skid_word_in  = push_word;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_word_in  = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   // The skid entry only fills behind a held output word.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output is empty");

   // No word arrives while both entries are taken.
   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("result pushed into a full buffer");

   // A drained skid entry moves into the output register.
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> out_valid_ff)
      else $error("skid word lost on drain");

endmodule

/* rtl/core/tcp_option_address_extractor.sv */
// ----------------------------------------------------------------------------
// TCP option address extractor
// Walks TCP header options and reports the client address option.
// ----------------------------------------------------------------------------
// The block takes one byte of a TCP options area per word on the req_ channel,
// one word every clock cycle unless req_stall is high, and gives at most one word
// per header on the rsp_ channel. The word that carries req_first_byte also
// carries the header data offset, from which the area length is taken. The
// result word is decided by the byte that settles the outcome and is registered
// in the result buffer before it is presented on rsp_; the rest of the header
// is then ignored until the next first byte. Each byte takes a single walker
// state update between the input port and a two-entry result buffer. req_stall
// rises only when both result entries are held by a stalled rsp_ side. The
// address option kind and length are to be written on the csr_ port only while
// no header is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tcp_option_address_extractor import tcpoae_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_option_byte,
   input  logic        req_first_byte,
   input  logic [3:0]  req_data_offset,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_address_found,
   output logic [2:0]  rsp_outcome,
   output logic [15:0] rsp_client_port,
   output logic [31:0] rsp_client_ip,

   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]   addr_kind_ff;
   logic [5:0]   addr_len_ff;
   logic         req_accept;
   logic         res_valid;
   rsp_word_type res_word;
   rsp_word_type rsp_word;

   // Configuration registers; the length register keeps the low six bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_kind_ff <= ADDR_KIND_RESET;
         addr_len_ff  <= ADDR_LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ADDR_KIND: addr_kind_ff <= csr_wdata;
            CSR_ADDR_LEN:  addr_len_ff  <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   assign req_accept = req_valid && !req_stall;

   tcpoae_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .option_byte (req_option_byte),
      .first_byte  (req_first_byte),
      .data_offset (req_data_offset),
      .cfg_kind    (addr_kind_ff),
      .cfg_len     (addr_len_ff),
      .res_valid   (res_valid),
      .res_word    (res_word)
   );

   tcpoae_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   assign rsp_address_found = rsp_word.address_found;
   assign rsp_outcome       = rsp_word.outcome;
   assign rsp_client_port   = rsp_word.client_port;
   assign rsp_client_ip     = rsp_word.client_ip;

endmodule
